### rtl/cfwp_pkg.sv
// ----------------------------------------------------------------------------
// cfwp_pkg: shared definitions for the circular FIFO with peek
// Widths, request and status codes, and the classified command format.
// ----------------------------------------------------------------------------
`default_nettype none

package cfwp_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int REQ_W    = 3;
  localparam int CAP_W    = 5;
  localparam int CAP_MAX  = (2 ** CAP_W) - 1;
  localparam int PEEK_W   = 5;
  localparam int MAX_PEEK = 16;
  localparam int STATUS_W = 2;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQUEUE   = 3'd0,
    REQ_DEQUEUE   = 3'd1,
    REQ_PEEK_HEAD = 3'd2,
    REQ_PEEK_TAIL = 3'd3,
    REQ_CLEAR     = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_ENQUEUE,
    OP_DEQUEUE,
    OP_PEEK_HEAD,
    OP_PEEK_TAIL,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [PEEK_W-1:0] count;
  } cmd_ctl_t;

endpackage

`default_nettype wire

### rtl/cfwp_if.sv
// ----------------------------------------------------------------------------
// cfwp_if: channel interfaces of the circular FIFO with peek
// Request, result and capacity write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfwp_item_if #(
  parameter int WORD_BITS = cfwp_pkg::WORD_BITS_DEF
);
  import cfwp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [WORD_BITS-1:0] word_in;
  logic [PEEK_W-1:0]    peek_count;

  modport source (output valid, output req_type, output word_in, output peek_count,
                  input ready);
  modport sink (input valid, input req_type, input word_in, input peek_count,
                output ready);
endinterface

interface cfwp_result_if #(
  parameter int WORD_BITS = cfwp_pkg::WORD_BITS_DEF
);
  import cfwp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [WORD_BITS-1:0] word_out;
  logic [CAP_W-1:0]     fill_level;
  logic                 last;

  modport source (output valid, output status, output word_out, output fill_level,
                  output last, input ready);
  modport sink (input valid, input status, input word_out, input fill_level,
                input last, output ready);
endinterface

interface cfwp_cfg_if;
  import cfwp_pkg::*;

  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

### rtl/cfwp_front.sv
// ----------------------------------------------------------------------------
// cfwp_front: request intake
// Accepts requests, decodes the request code and normalizes the peek count.
// ----------------------------------------------------------------------------
`default_nettype none

module cfwp_front #(
  parameter int WORD_BITS = cfwp_pkg::WORD_BITS_DEF
) (
  cfwp_item_if.sink            item,
  input  logic                 cmdq_full,
  output logic                 push,
  output cfwp_pkg::cmd_ctl_t   push_ctl,
  output logic [WORD_BITS-1:0] push_word
);
  import cfwp_pkg::*;

  localparam logic [PEEK_W-1:0] PEEK_TOP = PEEK_W'(MAX_PEEK);

  assign item.ready = !cmdq_full;
  assign push       = item.valid && !cmdq_full;
  assign push_word  = item.word_in;

  always_comb begin
    case (req_t'(item.req_type))
      REQ_ENQUEUE:   push_ctl.op = OP_ENQUEUE;
      REQ_DEQUEUE:   push_ctl.op = OP_DEQUEUE;
      REQ_PEEK_HEAD: push_ctl.op = OP_PEEK_HEAD;
      REQ_PEEK_TAIL: push_ctl.op = OP_PEEK_TAIL;
      REQ_CLEAR:     push_ctl.op = OP_CLEAR;
      default:       push_ctl.op = OP_NOP;
    endcase
    if (item.peek_count == '0) begin
      push_ctl.count = PEEK_W'(1);
    end else if (item.peek_count > PEEK_TOP) begin
      push_ctl.count = PEEK_TOP;
    end else begin
      push_ctl.count = item.peek_count;
    end
  end

endmodule

`default_nettype wire

### rtl/cfwp_cmd_queue.sv
// ----------------------------------------------------------------------------
// cfwp_cmd_queue: command queue between intake and execution
// A short first-in first-out buffer of decoded commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cfwp_cmd_queue #(
  parameter int WORD_BITS = cfwp_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cfwp_pkg::cmd_ctl_t   push_ctl,
  input  logic [WORD_BITS-1:0] push_word,
  output logic                 full,
  input  logic                 pop,
  output logic                 cmd_valid,
  output cfwp_pkg::cmd_ctl_t   cmd_ctl,
  output logic [WORD_BITS-1:0] cmd_word
);
  import cfwp_pkg::*;

  localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QP_W-1:0] LAST_SLOT = QP_W'(QUEUE_DEPTH - 1);
  localparam logic [QC_W-1:0] FULL_FILL = QC_W'(QUEUE_DEPTH);

  cmd_ctl_t             ctl_q  [QUEUE_DEPTH];
  logic [WORD_BITS-1:0] word_q [QUEUE_DEPTH];
  logic [QP_W-1:0]      wr_ptr;
  logic [QP_W-1:0]      rd_ptr;
  logic [QC_W-1:0]      fill;

  assign full      = (fill == FULL_FILL);
  assign cmd_valid = (fill != '0);
  assign cmd_ctl   = ctl_q[rd_ptr];
  assign cmd_word  = word_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q[wr_ptr]  <= push_ctl;
      word_q[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + QP_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + QP_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QC_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/cfwp_back.sv
// ----------------------------------------------------------------------------
// cfwp_back: command execution
// Holds the ring storage, pointers and capacity, and produces the results.
// ----------------------------------------------------------------------------
`default_nettype none

module cfwp_back #(
  parameter int DEPTH     = cfwp_pkg::DEPTH_DEF,
  parameter int WORD_BITS = cfwp_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  cfwp_pkg::cmd_ctl_t   cmd_ctl,
  input  logic [WORD_BITS-1:0] cmd_word,
  output logic                 pop,
  cfwp_result_if.source        result,
  cfwp_cfg_if.sink             cfg
);
  import cfwp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int AW    = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
  localparam logic [CAP_W-1:0] CAP_TOP = CAP_W'((DEPTH > CAP_MAX) ? CAP_MAX : DEPTH);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [CAP_W-1:0] cap_v);
    logic [AW-1:0] s;
    s = AW'(p) + AW'(1);
    return (s >= AW'(cap_v)) ? '0 : s[PTR_W-1:0];
  endfunction

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata;

  state_t               state;
  logic [PTR_W-1:0]     head;
  logic [PTR_W-1:0]     tail;
  logic [CAP_W-1:0]     count;
  logic [CAP_W-1:0]     cap;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PEEK_W-1:0]    remain;

  logic                 res_valid;
  status_t              res_status;
  logic [WORD_BITS-1:0] res_word;
  logic [CAP_W-1:0]     res_fill;
  logic                 res_last;

  logic                 can_load;
  logic                 is_full;
  logic                 is_empty;
  logic [PTR_W-1:0]     tail_prev;
  logic [AW-1:0]        tail_prev_wide;
  logic                 mem_we;
  logic                 mem_re;
  logic [PTR_W-1:0]     mem_raddr;
  logic [CAP_W-1:0]     cap_clamped;
  logic [PEEK_W-1:0]    peek_n;

  assign result.valid      = res_valid;
  assign result.status     = res_status;
  assign result.word_out   = res_word;
  assign result.fill_level = res_fill;
  assign result.last       = res_last;
  assign cfg.ready         = 1'b1;

  assign can_load       = !res_valid || result.ready;
  assign is_full        = (count >= cap);
  assign is_empty       = (count == '0);
  assign pop            = (state == S_IDLE) && cmd_valid && can_load;
  assign tail_prev_wide = (tail == '0) ? (AW'(cap) - AW'(1)) : (AW'(tail) - AW'(1));
  assign tail_prev      = tail_prev_wide[PTR_W-1:0];
  assign peek_n         = (PEEK_W'(count) < cmd_ctl.count) ? PEEK_W'(count) : cmd_ctl.count;
  assign mem_we         = pop && (cmd_ctl.op == OP_ENQUEUE) && !is_full;

  always_comb begin
    if (cfg.capacity == '0) begin
      cap_clamped = CAP_W'(1);
    end else if (cfg.capacity > CAP_TOP) begin
      cap_clamped = CAP_TOP;
    end else begin
      cap_clamped = cfg.capacity;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = head;
    if (pop && !is_empty) begin
      case (cmd_ctl.op)
        OP_DEQUEUE, OP_PEEK_HEAD: begin
          mem_re = 1'b1;
        end
        OP_PEEK_TAIL: begin
          mem_re    = 1'b1;
          mem_raddr = tail_prev;
        end
        default: begin
          mem_re = 1'b0;
        end
      endcase
    end else if ((state == S_READ) && can_load && (remain != PEEK_W'(1))) begin
      mem_re    = 1'b1;
      mem_raddr = advance(rd_ptr, cap);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= cmd_word;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      cap       <= CAP_TOP;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            res_status <= ST_DONE;
            res_word   <= '0;
            res_fill   <= count;
            res_last   <= 1'b1;
            case (cmd_ctl.op)
              OP_ENQUEUE: begin
                res_valid <= 1'b1;
                if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  tail     <= advance(tail, cap);
                  count    <= count + CAP_W'(1);
                  res_fill <= count + CAP_W'(1);
                end
              end
              OP_DEQUEUE: begin
                if (is_empty) begin
                  res_valid  <= 1'b1;
                  res_status <= ST_EMPTY;
                end else begin
                  head   <= advance(head, cap);
                  count  <= count - CAP_W'(1);
                  rd_ptr <= head;
                  remain <= PEEK_W'(1);
                  state  <= S_READ;
                end
              end
              OP_PEEK_HEAD: begin
                if (is_empty) begin
                  res_valid  <= 1'b1;
                  res_status <= ST_EMPTY;
                end else begin
                  rd_ptr <= head;
                  remain <= peek_n;
                  state  <= S_READ;
                end
              end
              OP_PEEK_TAIL: begin
                if (is_empty) begin
                  res_valid  <= 1'b1;
                  res_status <= ST_EMPTY;
                end else begin
                  rd_ptr <= tail_prev;
                  remain <= PEEK_W'(1);
                  state  <= S_READ;
                end
              end
              OP_CLEAR: begin
                res_valid <= 1'b1;
                head      <= '0;
                tail      <= '0;
                count     <= '0;
                res_fill  <= '0;
              end
              default: begin
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          if (can_load) begin
            res_valid  <= 1'b1;
            res_status <= ST_DONE;
            res_word   <= rdata;
            res_fill   <= count;
            res_last   <= (remain == PEEK_W'(1));
            if (remain == PEEK_W'(1)) begin
              state <= S_IDLE;
            end else begin
              remain <= remain - PEEK_W'(1);
              rd_ptr <= advance(rd_ptr, cap);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg.valid) begin
        cap   <= cap_clamped;
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/circular_fifo_with_peek.sv
// ----------------------------------------------------------------------------
// circular_fifo_with_peek: ring-buffer FIFO with peek requests
// Channel         Dir  Handshake     Payload
// item            in   valid/ready   req_type, word_in, peek_count
// result          out  valid/ready   status, word_out, fill_level, last
// cfg             in   valid/ready   capacity (ready is always high)
//
// Enqueue, clear and rejected requests are answered directly by the
// execution stage; dequeue and peek requests go through a read state that
// returns their words one at a time from the registered read port of the
// storage. A two-entry command queue sits between intake and execution;
// execution holds while a result waits and intake runs until the queue fills.
// Synchronous reset empties the FIFO and sets capacity to min(DEPTH, CAP_MAX).
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_with_peek #(
  parameter int DEPTH     = cfwp_pkg::DEPTH_DEF,
  parameter int WORD_BITS = cfwp_pkg::WORD_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  cfwp_item_if.sink     item,
  cfwp_result_if.source result,
  cfwp_cfg_if.sink      cfg
);
  import cfwp_pkg::*;

  logic                 push;
  cmd_ctl_t             push_ctl;
  logic [WORD_BITS-1:0] push_word;
  logic                 cmdq_full;
  logic                 pop;
  logic                 cmd_valid;
  cmd_ctl_t             cmd_ctl;
  logic [WORD_BITS-1:0] cmd_word;

  cfwp_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .item      (item),
    .cmdq_full (cmdq_full),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_word (push_word)
  );

  cfwp_cmd_queue #(
    .WORD_BITS (WORD_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_word (push_word),
    .full      (cmdq_full),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd_ctl   (cmd_ctl),
    .cmd_word  (cmd_word)
  );

  cfwp_back #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ctl   (cmd_ctl),
    .cmd_word  (cmd_word),
    .pop       (pop),
    .result    (result),
    .cfg       (cfg)
  );

endmodule

`default_nettype wire
